/* sv/htd_pkg.sv */
package htd_pkg;

  // Tree limits
  localparam int unsigned MaxSymbols = 256;
  localparam int unsigned MaxNodes   = 511;

  // Field and index widths
  localparam int unsigned ValW   = 8;
  localparam int unsigned NodeW  = $clog2(MaxNodes);
  localparam int unsigned OrdW   = $clog2(MaxSymbols);
  localparam int unsigned StackW = $clog2(MaxSymbols);
  localparam int unsigned ChildW = (NodeW > OrdW) ? NodeW : OrdW;
  localparam int unsigned NodeCntW = $clog2(MaxNodes + 1);
  localparam int unsigned LeafCntW = $clog2(MaxSymbols + 1);
  localparam int unsigned CntW = (NodeCntW > LeafCntW) ? NodeCntW : LeafCntW;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SHAPE = 2'd1,
    CMD_ALPHA = 2'd2,
    CMD_DATA  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SYMBOL    = 3'd1,
    ST_COMPLETE  = 3'd2,
    ST_EXCESS    = 3'd3,
    ST_ALPH_OVF  = 3'd4,
    ST_NOT_READY = 3'd5,
    ST_NODE_OVF  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_SHAPE = 2'd1,
    PH_ALPHA = 2'd2,
    PH_READY = 2'd3
  } phase_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [ValW-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] symbol;
  } out_item_t;

  // Per-node entry: leaf flag and leaf ordinal of the node itself
  typedef struct packed {
    logic            leaf;
    logic [OrdW-1:0] ord;
  } self_ent_t;

  // Right child of an internal node: leaf ordinal or node index
  typedef struct packed {
    logic              leaf;
    logic [ChildW-1:0] idx;
  } right_ent_t;

  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] raddr;
    logic             we;
    logic [NodeW-1:0] waddr;
    self_ent_t        wdata;
  } self_req_t;

  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] raddr;
    logic             we;
    logic [NodeW-1:0] waddr;
    right_ent_t       wdata;
  } right_req_t;

  typedef struct packed {
    logic            re;
    logic [OrdW-1:0] raddr;
    logic            we;
    logic [OrdW-1:0] waddr;
    logic [ValW-1:0] wdata;
  } sym_req_t;

  typedef struct packed {
    logic              re;
    logic [StackW-1:0] raddr;
    logic              we;
    logic [StackW-1:0] waddr;
    logic [NodeW-1:0]  wdata;
  } stack_req_t;

endpackage

/* sv/huffman_tree_load_and_bit_decoder_top.sv */
// Huffman tree loader and bitwise decoder. Each input item (clear, shape bit, alphabet byte
// or data bit) gives exactly one result item (status and symbol). Accepting an item starts
// its read of the node, symbol or build stack memory; it retires once the registered read
// data is back and the output register has room, and no new item is taken before then. The
// item that makes the tree ready also holds off the next item while the root entry is
// fetched from the node memories. A finished result waits in an output register while the
// next item is accepted. The node, symbol and stack memories need no clearing pass after
// reset: the counters make sure that data read from an entry not yet written is never used.
module huffman_tree_load_and_bit_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  htd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htd_pkg::out_item_t out_item_o
);

  htd_pkg::self_req_t          self_req;
  htd_pkg::right_req_t         right_req;
  htd_pkg::sym_req_t           sym_req;
  htd_pkg::stack_req_t         stack_req;
  logic [$bits(htd_pkg::self_ent_t)-1:0]  self_rdata;
  logic [$bits(htd_pkg::right_ent_t)-1:0] right_rdata;
  logic [htd_pkg::ValW-1:0]    sym_rdata;
  logic [htd_pkg::NodeW-1:0]   stack_rdata;

  logic                        out_free;
  logic                        res_valid;
  htd_pkg::out_item_t          res_item;
  logic                        out_valid_q, out_valid_d;
  htd_pkg::out_item_t          out_item_q, out_item_d;

  htd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .self_req_o  (self_req),
    .self_rd_i   (htd_pkg::self_ent_t'(self_rdata)),
    .right_req_o (right_req),
    .right_rd_i  (htd_pkg::right_ent_t'(right_rdata)),
    .sym_req_o   (sym_req),
    .sym_rd_i    (sym_rdata),
    .stack_req_o (stack_req),
    .stack_rd_i  (stack_rdata)
  );

  // Leaf flag and ordinal of each node
  htd_ram #(
    .Width ($bits(htd_pkg::self_ent_t)),
    .Depth (htd_pkg::MaxNodes)
  ) u_self_ram (
    .clk_i   (clk_i),
    .re_i    (self_req.re),
    .raddr_i (self_req.raddr),
    .we_i    (self_req.we),
    .waddr_i (self_req.waddr),
    .wdata_i (self_req.wdata),
    .rdata_o (self_rdata)
  );

  // Right child of each internal node
  htd_ram #(
    .Width ($bits(htd_pkg::right_ent_t)),
    .Depth (htd_pkg::MaxNodes)
  ) u_right_ram (
    .clk_i   (clk_i),
    .re_i    (right_req.re),
    .raddr_i (right_req.raddr),
    .we_i    (right_req.we),
    .waddr_i (right_req.waddr),
    .wdata_i (right_req.wdata),
    .rdata_o (right_rdata)
  );

  // Alphabet bytes in leaf order
  htd_ram #(
    .Width (htd_pkg::ValW),
    .Depth (htd_pkg::MaxSymbols)
  ) u_sym_ram (
    .clk_i   (clk_i),
    .re_i    (sym_req.re),
    .raddr_i (sym_req.raddr),
    .we_i    (sym_req.we),
    .waddr_i (sym_req.waddr),
    .wdata_i (sym_req.wdata),
    .rdata_o (sym_rdata)
  );

  // Internal nodes awaiting their right child
  htd_ram #(
    .Width (htd_pkg::NodeW),
    .Depth (htd_pkg::MaxSymbols)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .re_i    (stack_req.re),
    .raddr_i (stack_req.raddr),
    .we_i    (stack_req.we),
    .waddr_i (stack_req.waddr),
    .wdata_i (stack_req.wdata),
    .rdata_o (stack_rdata)
  );

  // Output register: load a new result when empty or being taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_free) begin
      out_valid_d = res_valid;
    end
    if (res_valid) begin
      out_item_d = res_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  // One item in flight: an accepted item blocks the next one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is still in flight");

  // Retire only when the output register can take the result
  a_retire_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> out_free)
    else $error("result produced while output register is blocked");

  // Drain the output register when taken and nothing new arrives
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !res_valid) |=> !out_valid_o)
    else $error("taken result was repeated");
`endif

endmodule

/* sv/htd_ram.sv */
module htd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                                      clk_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/htd_ctrl.sv */
module htd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  htd_pkg::in_item_t     in_item_i,
  output logic                  in_stall_o,
  input  logic                  out_free_i,
  output logic                  res_valid_o,
  output htd_pkg::out_item_t    res_item_o,
  output htd_pkg::self_req_t    self_req_o,
  input  htd_pkg::self_ent_t    self_rd_i,
  output htd_pkg::right_req_t   right_req_o,
  input  htd_pkg::right_ent_t   right_rd_i,
  output htd_pkg::sym_req_t     sym_req_o,
  input  logic [htd_pkg::ValW-1:0]  sym_rd_i,
  output htd_pkg::stack_req_t   stack_req_o,
  input  logic [htd_pkg::NodeW-1:0] stack_rd_i
);

  // Control state
  logic                         busy_q, busy_d;
  logic                         refetch_q, refetch_d;
  htd_pkg::phase_e              phase_q, phase_d;
  logic [htd_pkg::CntW-1:0]     node_cnt_q, node_cnt_d;
  logic [htd_pkg::CntW-1:0]     leaf_cnt_q, leaf_cnt_d;
  logic [htd_pkg::CntW-1:0]     alph_cnt_q, alph_cnt_d;
  logic [htd_pkg::StackW-1:0]   depth_q, depth_d;
  logic                         prev_leaf_q, prev_leaf_d;
  logic [htd_pkg::NodeW-1:0]    walk_q, walk_d;

  // Item awaiting retirement
  htd_pkg::cmd_e                b_cmd_q, b_cmd_d;
  logic [htd_pkg::ValW-1:0]     b_value_q, b_value_d;
  logic                         b_nr_q, b_nr_d;
  logic                         b_hit_q, b_hit_d;
  logic [htd_pkg::ChildW-1:0]   b_idx_q, b_idx_d;

  logic                         accept;
  logic                         fire;
  logic                         ready;
  logic                         ch_leaf;
  logic [htd_pkg::ChildW-1:0]   ch_idx;

  assign in_stall_o = busy_q || refetch_q;
  assign accept     = in_valid_i && !in_stall_o;
  assign fire       = busy_q && out_free_i;
  assign ready      = (phase_q == htd_pkg::PH_READY) && (node_cnt_q >= htd_pkg::CntW'(2));

  // Pick the child of the current node; left child is always the next node in pre-order
  always_comb begin
    if (in_item_i.value[0]) begin
      ch_leaf = right_rd_i.leaf;
      ch_idx  = right_rd_i.idx;
    end else begin
      ch_leaf = self_rd_i.leaf;
      if (self_rd_i.leaf) begin
        ch_idx = htd_pkg::ChildW'(self_rd_i.ord);
      end else begin
        ch_idx = htd_pkg::ChildW'(htd_pkg::NodeW'(walk_q + 1'b1));
      end
    end
  end

  // Issue reads on accept, retire the item once its read data is back and the output has room
  always_comb begin
    logic                       leaf;
    logic                       pop;
    logic [htd_pkg::StackW-1:0] depth_pop;
    logic [htd_pkg::CntW-1:0]   leaf_new;
    logic [htd_pkg::CntW-1:0]   alph_inc;

    leaf      = b_value_q[0];
    pop       = 1'b0;
    depth_pop = depth_q;
    leaf_new  = leaf_cnt_q;
    alph_inc  = htd_pkg::CntW'(alph_cnt_q + 1'b1);

    busy_d      = busy_q;
    refetch_d   = refetch_q;
    phase_d     = phase_q;
    node_cnt_d  = node_cnt_q;
    leaf_cnt_d  = leaf_cnt_q;
    alph_cnt_d  = alph_cnt_q;
    depth_d     = depth_q;
    prev_leaf_d = prev_leaf_q;
    walk_d      = walk_q;
    b_cmd_d     = b_cmd_q;
    b_value_d   = b_value_q;
    b_nr_d      = b_nr_q;
    b_hit_d     = b_hit_q;
    b_idx_d     = b_idx_q;

    self_req_o  = '0;
    right_req_o = '0;
    sym_req_o   = '0;
    stack_req_o = '0;

    res_valid_o       = 1'b0;
    res_item_o.status = htd_pkg::ST_OK;
    res_item_o.symbol = '0;

    // On accept: latch the item and start its memory read
    if (accept) begin
      busy_d    = 1'b1;
      b_cmd_d   = in_item_i.cmd;
      b_value_d = in_item_i.value;
      b_nr_d    = !ready;
      b_hit_d   = ch_leaf;
      b_idx_d   = ch_idx;
      case (in_item_i.cmd)
        htd_pkg::CMD_SHAPE: begin
          stack_req_o.re    = 1'b1;
          stack_req_o.raddr = htd_pkg::StackW'(depth_q - 1'b1);
        end
        htd_pkg::CMD_DATA: begin
          if (ready) begin
            if (ch_leaf) begin
              sym_req_o.re    = 1'b1;
              sym_req_o.raddr = ch_idx[htd_pkg::OrdW-1:0];
            end else begin
              self_req_o.re    = 1'b1;
              self_req_o.raddr = htd_pkg::NodeW'(ch_idx + 1'b1);
              right_req_o.re    = 1'b1;
              right_req_o.raddr = ch_idx[htd_pkg::NodeW-1:0];
            end
          end
        end
        default: ;
      endcase
    end

    // Load the root entry once the tree turns ready
    if (refetch_q) begin
      refetch_d         = 1'b0;
      self_req_o.re     = 1'b1;
      self_req_o.raddr  = htd_pkg::NodeW'(1);
      right_req_o.re    = 1'b1;
      right_req_o.raddr = '0;
    end

    // On retire: update state and hand the result on
    if (fire) begin
      busy_d      = 1'b0;
      res_valid_o = 1'b1;
      case (b_cmd_q)
        htd_pkg::CMD_CLEAR: begin
          phase_d    = htd_pkg::PH_EMPTY;
          node_cnt_d = '0;
          leaf_cnt_d = '0;
          alph_cnt_d = '0;
          depth_d    = '0;
          walk_d     = '0;
        end
        htd_pkg::CMD_SHAPE: begin
          if (phase_q == htd_pkg::PH_ALPHA || phase_q == htd_pkg::PH_READY) begin
            res_item_o.status = htd_pkg::ST_EXCESS;
          end else if (node_cnt_q >= htd_pkg::CntW'(htd_pkg::MaxNodes)) begin
            res_item_o.status = htd_pkg::ST_NODE_OVF;
          end else if (leaf && leaf_cnt_q >= htd_pkg::CntW'(htd_pkg::MaxSymbols)) begin
            res_item_o.status = htd_pkg::ST_NODE_OVF;
          end else if (!leaf && htd_pkg::CntW'(node_cnt_q - leaf_cnt_q) >=
                       htd_pkg::CntW'(htd_pkg::MaxSymbols - 1)) begin
            res_item_o.status = htd_pkg::ST_NODE_OVF;
          end else begin
            // A leaf before this node closes the left side: it is the right child of the top
            pop = (node_cnt_q != '0) && prev_leaf_q && (depth_q != '0);
            if (pop) begin
              depth_pop              = htd_pkg::StackW'(depth_q - 1'b1);
              right_req_o.we         = 1'b1;
              right_req_o.waddr      = stack_rd_i;
              right_req_o.wdata.leaf = leaf;
              right_req_o.wdata.idx  = leaf ?
                  htd_pkg::ChildW'(leaf_cnt_q[htd_pkg::OrdW-1:0]) :
                  htd_pkg::ChildW'(node_cnt_q[htd_pkg::NodeW-1:0]);
            end
            self_req_o.we         = 1'b1;
            self_req_o.waddr      = node_cnt_q[htd_pkg::NodeW-1:0];
            self_req_o.wdata.leaf = leaf;
            self_req_o.wdata.ord  = leaf_cnt_q[htd_pkg::OrdW-1:0];
            // Push an internal node until its right child arrives
            if (!leaf) begin
              stack_req_o.we    = 1'b1;
              stack_req_o.waddr = depth_pop;
              stack_req_o.wdata = node_cnt_q[htd_pkg::NodeW-1:0];
              depth_d           = htd_pkg::StackW'(depth_pop + 1'b1);
            end else begin
              depth_d  = depth_pop;
              leaf_new = htd_pkg::CntW'(leaf_cnt_q + 1'b1);
            end
            leaf_cnt_d  = leaf_new;
            node_cnt_d  = htd_pkg::CntW'(node_cnt_q + 1'b1);
            prev_leaf_d = leaf;
            phase_d     = htd_pkg::PH_SHAPE;
            // Shape closes on a leaf with nothing left pending
            if (leaf && depth_pop == '0) begin
              if (alph_cnt_q >= leaf_new) begin
                res_item_o.status = (alph_cnt_q > leaf_new) ? htd_pkg::ST_ALPH_OVF :
                                                              htd_pkg::ST_COMPLETE;
                alph_cnt_d = leaf_new;
                phase_d    = htd_pkg::PH_READY;
                walk_d     = '0;
                refetch_d  = 1'b1;
              end else begin
                phase_d = htd_pkg::PH_ALPHA;
              end
            end
          end
        end
        htd_pkg::CMD_ALPHA: begin
          if (phase_q == htd_pkg::PH_ALPHA || phase_q == htd_pkg::PH_READY) begin
            if (alph_cnt_q >= leaf_cnt_q ||
                alph_cnt_q >= htd_pkg::CntW'(htd_pkg::MaxSymbols)) begin
              res_item_o.status = htd_pkg::ST_ALPH_OVF;
            end else begin
              sym_req_o.we    = 1'b1;
              sym_req_o.waddr = alph_cnt_q[htd_pkg::OrdW-1:0];
              sym_req_o.wdata = b_value_q;
              alph_cnt_d      = alph_inc;
              if (alph_inc == leaf_cnt_q) begin
                res_item_o.status = htd_pkg::ST_COMPLETE;
                phase_d           = htd_pkg::PH_READY;
                walk_d            = '0;
                refetch_d         = 1'b1;
              end
            end
          end else if (alph_cnt_q >= htd_pkg::CntW'(htd_pkg::MaxSymbols)) begin
            res_item_o.status = htd_pkg::ST_ALPH_OVF;
          end else begin
            sym_req_o.we    = 1'b1;
            sym_req_o.waddr = alph_cnt_q[htd_pkg::OrdW-1:0];
            sym_req_o.wdata = b_value_q;
            alph_cnt_d      = alph_inc;
          end
        end
        htd_pkg::CMD_DATA: begin
          if (b_nr_q) begin
            res_item_o.status = htd_pkg::ST_NOT_READY;
          end else if (b_hit_q) begin
            // Emit the symbol and reload the root entry for the next bit
            res_item_o.status = htd_pkg::ST_SYMBOL;
            res_item_o.symbol = sym_rd_i;
            walk_d            = '0;
            self_req_o.re     = 1'b1;
            self_req_o.raddr  = htd_pkg::NodeW'(1);
            right_req_o.re    = 1'b1;
            right_req_o.raddr = '0;
          end else begin
            walk_d = b_idx_q[htd_pkg::NodeW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      refetch_q   <= 1'b0;
      phase_q     <= htd_pkg::PH_EMPTY;
      node_cnt_q  <= '0;
      leaf_cnt_q  <= '0;
      alph_cnt_q  <= '0;
      depth_q     <= '0;
      prev_leaf_q <= 1'b0;
      walk_q      <= '0;
    end else begin
      busy_q      <= busy_d;
      refetch_q   <= refetch_d;
      phase_q     <= phase_d;
      node_cnt_q  <= node_cnt_d;
      leaf_cnt_q  <= leaf_cnt_d;
      alph_cnt_q  <= alph_cnt_d;
      depth_q     <= depth_d;
      prev_leaf_q <= prev_leaf_d;
      walk_q      <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_cmd_q   <= b_cmd_d;
    b_value_q <= b_value_d;
    b_nr_q    <= b_nr_d;
    b_hit_q   <= b_hit_d;
    b_idx_q   <= b_idx_d;
  end

endmodule

/* bench/huffman_tree_load_and_bit_decoder_top_test.sv */
`timescale 1ns / 100ps

module huffman_tree_load_and_bit_decoder_top_test;

  localparam int QuietLimit  = 2000;
  localparam int PressureAt  = 400;
  localparam int PressureLen = 300;
  localparam int TailCycles  = 12;
  localparam int SmallItems  = 340;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  htd_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  htd_pkg::out_item_t out_item;

  // Pending input items and the replies they are predicted to give
  htd_pkg::in_item_t  cmd_backlog[$];
  htd_pkg::out_item_t awaited_replies[$];
  htd_pkg::out_item_t want;

  // Predictor copy of the tree tables and the load/walk counters
  logic [htd_pkg::NodeW-1:0] kid0       [htd_pkg::MaxNodes];
  logic [htd_pkg::NodeW-1:0] kid1       [htd_pkg::MaxNodes];
  logic                      leaf_flag  [htd_pkg::MaxNodes];
  logic [htd_pkg::ValW-1:0]  sym_tab    [htd_pkg::MaxSymbols];
  logic [htd_pkg::NodeW-1:0] pend_stack [htd_pkg::MaxSymbols];
  int unsigned               pend_depth  = 0;
  int unsigned               nodes_used  = 0;
  int unsigned               leaves_used = 0;
  int unsigned               syms_loaded = 0;
  logic [htd_pkg::NodeW-1:0] cur_node    = '0;
  htd_pkg::phase_e           tree_phase  = htd_pkg::PH_EMPTY;

  int send_gap;
  int send_calm;
  int hold_left;
  int recv_calm;
  int replies_seen;
  bit pressure_done;
  int quiet_cycles;
  int fail_count;

  huffman_tree_load_and_bit_decoder_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always #5 clk_i = ~clk_i;

  // Advance the tree state by one item and return the reply it gives
  function automatic htd_pkg::out_item_t next_decode_reply(htd_pkg::in_item_t it);
    htd_pkg::out_item_t        r;
    int unsigned               n;
    logic [htd_pkg::NodeW-1:0] nid;
    logic [htd_pkg::NodeW-1:0] top;
    logic [htd_pkg::NodeW-1:0] nxt;
    logic                      bit0;
    r.status = htd_pkg::ST_OK;
    r.symbol = '0;
    bit0 = it.value[0];
    case (it.cmd)
      htd_pkg::CMD_CLEAR: begin
        pend_depth  = 0;
        nodes_used  = 0;
        leaves_used = 0;
        syms_loaded = 0;
        cur_node    = '0;
        tree_phase  = htd_pkg::PH_EMPTY;
      end
      htd_pkg::CMD_SHAPE: begin
        n   = nodes_used;
        nid = htd_pkg::NodeW'(n);
        if (tree_phase >= htd_pkg::PH_ALPHA) begin
          r.status = htd_pkg::ST_EXCESS;
        end else if (n >= htd_pkg::MaxNodes ||
                     (bit0 && leaves_used >= htd_pkg::MaxSymbols) ||
                     (!bit0 && (n - leaves_used) >= htd_pkg::MaxSymbols - 1)) begin
          r.status = htd_pkg::ST_NODE_OVF;
        end else begin
          // Link the new node to its parent: left child of an internal
          // predecessor, else right child of the innermost open node
          if (n > 0) begin
            if (!leaf_flag[htd_pkg::NodeW'(n - 1)]) begin
              kid0[htd_pkg::NodeW'(n - 1)] = nid;
            end else if (pend_depth > 0) begin
              pend_depth--;
              top = pend_stack[htd_pkg::StackW'(pend_depth)];
              if (top < htd_pkg::MaxNodes) kid1[top] = nid;
            end
          end
          leaf_flag[nid] = bit0;
          kid1[nid] = '0;
          if (bit0) begin
            kid0[nid] = htd_pkg::NodeW'(leaves_used);
            leaves_used++;
          end else begin
            kid0[nid] = '0;
            if (pend_depth < htd_pkg::MaxSymbols) begin
              pend_stack[htd_pkg::StackW'(pend_depth)] = nid;
              pend_depth++;
            end
          end
          nodes_used = n + 1;
          tree_phase = htd_pkg::PH_SHAPE;
          if (bit0 && pend_depth == 0) begin
            if (syms_loaded >= leaves_used) begin
              r.status = (syms_loaded > leaves_used) ? htd_pkg::ST_ALPH_OVF :
                                                       htd_pkg::ST_COMPLETE;
              syms_loaded = leaves_used;
              tree_phase = htd_pkg::PH_READY;
              cur_node = '0;
            end else begin
              tree_phase = htd_pkg::PH_ALPHA;
            end
          end
        end
      end
      htd_pkg::CMD_ALPHA: begin
        if (tree_phase >= htd_pkg::PH_ALPHA) begin
          if (syms_loaded >= leaves_used || syms_loaded >= htd_pkg::MaxSymbols) begin
            r.status = htd_pkg::ST_ALPH_OVF;
          end else begin
            sym_tab[htd_pkg::OrdW'(syms_loaded)] = it.value;
            syms_loaded++;
            if (syms_loaded == leaves_used) begin
              tree_phase = htd_pkg::PH_READY;
              cur_node = '0;
              r.status = htd_pkg::ST_COMPLETE;
            end
          end
        end else if (syms_loaded >= htd_pkg::MaxSymbols) begin
          r.status = htd_pkg::ST_ALPH_OVF;
        end else begin
          sym_tab[htd_pkg::OrdW'(syms_loaded)] = it.value;
          syms_loaded++;
        end
      end
      htd_pkg::CMD_DATA: begin
        if (tree_phase != htd_pkg::PH_READY || nodes_used < 2) begin
          r.status = htd_pkg::ST_NOT_READY;
        end else begin
          nxt = bit0 ? kid1[cur_node] : kid0[cur_node];
          if (nxt >= htd_pkg::MaxNodes) nxt = '0;
          if (leaf_flag[nxt]) begin
            r.symbol = sym_tab[kid0[nxt][htd_pkg::OrdW-1:0]];
            r.status = htd_pkg::ST_SYMBOL;
            cur_node = '0;
          end else begin
            cur_node = nxt;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Pick an idle length: mostly none or short, a few long, and calm stretches
  function automatic int idle_length(inout int calm);
    int pick;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    pick = int'($urandom_range(0, 99));
    if (pick < 3) begin
      calm = int'($urandom_range(20, 60));
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  task automatic push_cmd(input htd_pkg::cmd_e c, input logic [htd_pkg::ValW-1:0] v);
    htd_pkg::in_item_t it;
    it.cmd   = c;
    it.value = v;
    cmd_backlog.insert(cmd_backlog.size(), it);
  endtask

  // Shape and data bits carry random upper bits, which the block ignores
  task automatic queue_bit(input htd_pkg::cmd_e c, input logic b);
    push_cmd(c, (htd_pkg::ValW'($urandom) & 8'hFE) | htd_pkg::ValW'(b));
  endtask

  task automatic queue_data_bits(input int count, input int zero_pct);
    repeat (count) queue_bit(htd_pkg::CMD_DATA, $urandom_range(0, 99) >= zero_pct);
  endtask

  // Load a random full tree with the given leaf count, alphabet bytes placed
  // before, during or after the shape, sometimes with surplus or excess
  task automatic load_random_tree(input int leaves);
    int pick;
    int pre;
    int sent;
    int slots;
    int inner_left;
    pick = int'($urandom_range(0, 9));
    if (pick < 3) pre = 0;
    else if (pick < 6) pre = int'($urandom_range(0, leaves));
    else if (pick < 8) pre = leaves;
    else pre = leaves + int'($urandom_range(1, 3));
    repeat (pre) push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
    sent = pre;
    slots = 1;
    inner_left = leaves - 1;
    while (slots > 0) begin
      if (inner_left > 0 && (slots == 1 || $urandom_range(0, 1) == 1)) begin
        queue_bit(htd_pkg::CMD_SHAPE, 1'b0);
        slots++;
        inner_left--;
      end else begin
        queue_bit(htd_pkg::CMD_SHAPE, 1'b1);
        slots--;
      end
      if (slots > 0 && sent < leaves && $urandom_range(0, 3) == 0) begin
        push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
        sent++;
      end
    end
    while (sent < leaves) begin
      push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
      sent++;
    end
    if ($urandom_range(0, 4) == 0) push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
    if ($urandom_range(0, 4) == 0) queue_bit(htd_pkg::CMD_SHAPE, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_noise(input int count, input bit with_clear);
    int pick;
    repeat (count) begin
      pick = int'($urandom_range(0, 9));
      if (pick == 0 && with_clear) push_cmd(htd_pkg::CMD_CLEAR, htd_pkg::ValW'($urandom));
      else if (pick < 3) push_cmd(htd_pkg::CMD_SHAPE, htd_pkg::ValW'($urandom));
      else if (pick < 5) push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
      else push_cmd(htd_pkg::CMD_DATA, htd_pkg::ValW'($urandom));
    end
  endtask

  // Present items from the backlog, with random idle gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_replies.insert(awaited_replies.size(), next_decode_reply(in_item));
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0 || cmd_backlog.size() == 0) begin
          in_valid <= 1'b0;
          if (send_gap > 0) send_gap <= send_gap - 1;
        end else begin
          in_valid <= 1'b1;
          in_item  <= cmd_backlog.pop_front();
          send_gap <= idle_length(send_calm);
        end
      end
    end
  end

  // Check each reply against the oldest prediction; stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (awaited_replies.size() == 0) begin
          $display("%0t: unexpected reply: status %0d symbol %02h", $time,
                   out_item.status, out_item.symbol);
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time,
                     want.status, out_item.status);
            fail_count++;
          end
          if (out_item.symbol !== want.symbol) begin
            $display("%0t: symbol mismatch: expected %02h actual %02h", $time,
                     want.symbol, out_item.symbol);
            fail_count++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up
      if (!pressure_done && replies_seen >= PressureAt) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        hold_left <= PressureLen;
      end else if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else begin
        out_stall <= 1'b0;
        hold_left <= idle_length(recv_calm);
      end
    end
  end

  // End the run when nothing is accepted for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("huffman_tree_load_and_bit_decoder_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int target;
    int kind;
    int leaves;

    // Data bit on an empty tree, alphabet ahead of a two-leaf shape
    push_cmd(htd_pkg::CMD_DATA, 8'hFF);
    push_cmd(htd_pkg::CMD_ALPHA, 8'h00);
    push_cmd(htd_pkg::CMD_ALPHA, 8'hFF);
    push_cmd(htd_pkg::CMD_SHAPE, 8'hFE);
    push_cmd(htd_pkg::CMD_DATA, 8'h00);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h01);
    push_cmd(htd_pkg::CMD_SHAPE, 8'hFF);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h00);
    push_cmd(htd_pkg::CMD_DATA, 8'h00);
    push_cmd(htd_pkg::CMD_DATA, 8'hFF);
    push_cmd(htd_pkg::CMD_ALPHA, 8'h55);
    // Leaf-only root: excess shape, not ready before and after the alphabet
    push_cmd(htd_pkg::CMD_CLEAR, 8'hAA);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h01);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h01);
    push_cmd(htd_pkg::CMD_DATA, 8'h01);
    push_cmd(htd_pkg::CMD_ALPHA, 8'h3C);
    push_cmd(htd_pkg::CMD_DATA, 8'h00);
    push_cmd(htd_pkg::CMD_DATA, 8'h01);
    // Surplus alphabet bytes dropped when the shape completes
    push_cmd(htd_pkg::CMD_CLEAR, 8'h55);
    push_cmd(htd_pkg::CMD_ALPHA, 8'hA1);
    push_cmd(htd_pkg::CMD_ALPHA, 8'hB2);
    push_cmd(htd_pkg::CMD_ALPHA, 8'hC3);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h00);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h01);
    push_cmd(htd_pkg::CMD_SHAPE, 8'h01);
    push_cmd(htd_pkg::CMD_DATA, 8'h01);
    push_cmd(htd_pkg::CMD_DATA, 8'h00);

    // Largest tree: full alphabet plus one, a chain of internal nodes that
    // hits the internal limit, then every leaf; walk mostly down the chain
    push_cmd(htd_pkg::CMD_CLEAR, 8'h00);
    repeat (htd_pkg::MaxSymbols + 1) push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
    repeat (htd_pkg::MaxSymbols) queue_bit(htd_pkg::CMD_SHAPE, 1'b0);
    repeat (htd_pkg::MaxSymbols) queue_bit(htd_pkg::CMD_SHAPE, 1'b1);
    push_cmd(htd_pkg::CMD_ALPHA, htd_pkg::ValW'($urandom));
    queue_data_bits(60, 95);
    queue_bit(htd_pkg::CMD_SHAPE, 1'b1);

    // Random loads, mostly well formed, the rest partial or noisy
    target = cmd_backlog.size() + SmallItems;
    while (cmd_backlog.size() < target) begin
      kind = int'($urandom_range(0, 99));
      push_cmd(htd_pkg::CMD_CLEAR, htd_pkg::ValW'($urandom));
      if (kind < 60) begin
        leaves = ($urandom_range(0, 9) == 0) ? int'($urandom_range(11, 64)) :
                                               int'($urandom_range(2, 10));
        if ($urandom_range(0, 5) == 0) begin
          queue_bit(htd_pkg::CMD_DATA, 1'($urandom_range(0, 1)));
        end
        load_random_tree(leaves);
        queue_data_bits(int'($urandom_range(8, 40)), 50);
      end else if (kind < 70) begin
        load_random_tree(1);
        queue_data_bits(int'($urandom_range(1, 4)), 50);
      end else if (kind < 85) begin
        repeat ($urandom_range(1, 8)) push_cmd(htd_pkg::CMD_SHAPE, htd_pkg::ValW'($urandom));
        push_noise(int'($urandom_range(2, 10)), 1'b1);
      end else begin
        load_random_tree(int'($urandom_range(2, 8)));
        push_noise(int'($urandom_range(10, 30)), 1'($urandom_range(0, 1)));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk_i);
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("huffman_tree_load_and_bit_decoder_top test passed");
    end else begin
      $display("huffman_tree_load_and_bit_decoder_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/htd_pkg.sv
sv/htd_ram.sv
sv/htd_ctrl.sv
sv/huffman_tree_load_and_bit_decoder_top.sv
bench/huffman_tree_load_and_bit_decoder_top_test.sv
